@@ rtl/ftzr_pkg.sv @@
// Shared types and constants for the flat triangle raster core.
package ftzr_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_DIV,
    ST_ROW,
    ST_RD,
    ST_PIX,
    ST_WB,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    DIV_S1,
    DIV_S2,
    DIV_MID
  } div_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;       // capture request
    logic     clr_step;   // clear pass write
    logic     div_start;
    div_sel_t div_sel;
    logic     part_init;  // set up edges for the current part
    logic     row_init;   // work out span ends of the current row
    logic     rd_issue;   // memory read at cursor
    logic     pix_eval;   // depth compare and write
    logic     pix_adv;
    logic     row_adv;
    logic     part_adv;
    logic     read_issue; // read request
    logic     out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic flat;        // all on one row
    logic div_done;
    logic clr_last;
    logic span_empty;
    logic pix_last;
    logic row_last;
    logic part_last;
    logic need_mid;
    logic part_skip;   // this part draws nothing
  } stat_t;

endpackage

@@ rtl/ftzr_div.sv @@
// Restoring divider, one quotient bit per cycle.
module ftzr_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        q    <= num;
        rem  <= '0;
        d    <= den;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/ftzr_ctrl.sv @@
// Sequencer for clear, draw and read requests.
module ftzr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ftzr_pkg::stat_t st,
  output ftzr_pkg::cmd_t  cmd
);
  ftzr_pkg::state_t state, state_next;
  ftzr_pkg::div_sel_t dsel, dsel_next;
  logic ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftzr_pkg::ST_CLEAR;
      dsel  <= ftzr_pkg::DIV_S1;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      dsel  <= dsel_next;
      ov    <= ov_next;
    end
  end

  assign out_valid = ov;

  always_comb begin
    cmd        = '0;
    state_next = state;
    dsel_next  = dsel;
    ov_next    = ov && !out_ready;
    in_ready   = 1'b0;
    cmd.div_sel = dsel;
    case (state)
      ftzr_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = ftzr_pkg::ST_IDLE;
      end
      ftzr_pkg::ST_IDLE: begin
        in_ready = !ov || out_ready;
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = ftzr_pkg::ST_SETUP;
        end
      end
      ftzr_pkg::ST_SETUP: begin
        if (st.is_read) begin
          cmd.read_issue = 1'b1;
          state_next = ftzr_pkg::ST_RESULT;
        end else if (st.flat) begin
          state_next = ftzr_pkg::ST_RESULT;
        end else begin
          dsel_next     = st.need_mid ? ftzr_pkg::DIV_MID : ftzr_pkg::DIV_S1;
          cmd.div_sel   = dsel_next;
          cmd.div_start = 1'b1;
          state_next    = ftzr_pkg::ST_DIV;
        end
      end
      ftzr_pkg::ST_DIV: begin
        if (st.div_done) begin
          if (dsel == ftzr_pkg::DIV_S1) begin
            dsel_next     = ftzr_pkg::DIV_S2;
            cmd.div_sel   = ftzr_pkg::DIV_S2;
            cmd.div_start = 1'b1;
          end else if (dsel == ftzr_pkg::DIV_MID) begin
            dsel_next     = ftzr_pkg::DIV_S1;
            cmd.div_sel   = ftzr_pkg::DIV_S1;
            cmd.div_start = 1'b1;
          end else begin
            cmd.part_init = 1'b1;
            state_next    = ftzr_pkg::ST_ROW;
          end
        end
      end
      ftzr_pkg::ST_ROW: begin
        if (st.part_skip) begin
          if (st.part_last) state_next = ftzr_pkg::ST_RESULT;
          else begin
            cmd.part_adv  = 1'b1;
            dsel_next     = ftzr_pkg::DIV_S1;
            cmd.div_sel   = ftzr_pkg::DIV_S1;
            cmd.div_start = 1'b1;
            state_next    = ftzr_pkg::ST_DIV;
          end
        end else begin
          cmd.row_init = 1'b1;
          state_next   = ftzr_pkg::ST_RD;
        end
      end
      ftzr_pkg::ST_RD: begin
        if (st.span_empty) begin
          cmd.row_adv = 1'b1;
          if (st.row_last) begin
            if (st.part_last) state_next = ftzr_pkg::ST_RESULT;
            else begin
              cmd.part_adv  = 1'b1;
              dsel_next     = ftzr_pkg::DIV_S1;
              cmd.div_sel   = ftzr_pkg::DIV_S1;
              cmd.div_start = 1'b1;
              state_next    = ftzr_pkg::ST_DIV;
            end
          end else state_next = ftzr_pkg::ST_ROW;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = ftzr_pkg::ST_PIX;
        end
      end
      ftzr_pkg::ST_PIX: begin
        cmd.pix_eval = 1'b1;
        state_next   = ftzr_pkg::ST_WB;
      end
      ftzr_pkg::ST_WB: begin
        if (st.pix_last) begin
          cmd.row_adv = 1'b1;
          if (st.row_last) begin
            if (st.part_last) state_next = ftzr_pkg::ST_RESULT;
            else begin
              cmd.part_adv  = 1'b1;
              dsel_next     = ftzr_pkg::DIV_S1;
              cmd.div_sel   = ftzr_pkg::DIV_S1;
              cmd.div_start = 1'b1;
              state_next    = ftzr_pkg::ST_DIV;
            end
          end else state_next = ftzr_pkg::ST_ROW;
        end else begin
          cmd.pix_adv  = 1'b1;
          cmd.rd_issue = 1'b1;
          state_next   = ftzr_pkg::ST_PIX;
        end
      end
      ftzr_pkg::ST_RESULT: begin
        if (!ov || out_ready) begin
          cmd.out_load = 1'b1;
          ov_next      = 1'b1;
          state_next   = ftzr_pkg::ST_IDLE;
        end
      end
      default: state_next = ftzr_pkg::ST_IDLE;
    endcase
  end
endmodule

@@ rtl/ftzr_dp.sv @@
// Datapath: vertex sort, slopes, edge stepping, span walk and pixel stores.
module ftzr_dp #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  ftzr_pkg::cmd_t  cmd,
  output ftzr_pkg::stat_t st,
  input  logic            action,
  input  logic [7:0]      x_a,
  input  logic [7:0]      y_a,
  input  logic [7:0]      x_b,
  input  logic [7:0]      y_b,
  input  logic [7:0]      x_c,
  input  logic [7:0]      y_c,
  input  logic [15:0]     tri_depth,
  input  logic [23:0]     tri_color,
  output logic [23:0]     pixel_color,
  output logic [15:0]     pixel_depth,
  output logic [16:0]     pixels_written
);
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int YW    = $clog2(SCREEN_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int CLW   = $clog2(DEPTH + 1);

  // stores
  logic [23:0] cmem [DEPTH];
  logic [15:0] dmem [DEPTH];
  logic [CLW-1:0] clr_cnt;
  logic [23:0] rd_c;
  logic [15:0] rd_d;

  // captured request
  logic        act;
  logic [7:0]  ax, ay, bx, by, cx, cy;
  logic [15:0] dep;
  logic [23:0] col;

  // sorted vertices
  logic [7:0] v0x, v0y, v1x, v1y, v2x, v2y, mx;
  logic [7:0] mid_x;

  // part set up: last row of the walk and direction
  logic        part;      // 0 first part, 1 second part
  logic        part_cur;  // part, or the part being entered this cycle
  logic        two_part;
  logic        up;        // flat-top part walks upward
  logic [7:0]  p_ay;
  logic signed [25:0] s1, s2;
  logic signed [25:0] e1, e2;
  logic [7:0]  row;

  // span walk
  logic [8:0]  hi;
  logic [8:0]  cur;
  logic [8:0]  cur_nx;
  logic [16:0] cnt;

  // divider
  logic [31:0] dnum, dquo;
  logic [15:0] dden;
  logic        ddone;
  logic        dneg;
  logic        dneg_r;

  // which result the divider is producing
  logic two_part_seen, s_sel;

  ftzr_div #(.NW(32), .DW(16)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(dnum), .den(dden),
    .quo(dquo), .done(ddone)
  );

  // split vertex x is usable in the cycle its division finishes
  assign mid_x    = (ddone && !two_part_seen) ? dquo[7:0] : mx;
  assign part_cur = part || cmd.part_adv;

  // stable sort by y
  always_comb begin
    logic [7:0] tx, ty;
    tx = '0; ty = '0;
    v0x = ax; v0y = ay; v1x = bx; v1y = by; v2x = cx; v2y = cy;
    if (v1y < v0y) begin
      tx = v0x; ty = v0y; v0x = v1x; v0y = v1y; v1x = tx; v1y = ty;
    end
    if (v2y < v1y) begin
      tx = v1x; ty = v1y; v1x = v2x; v1y = v2y; v2x = tx; v2y = ty;
      if (v1y < v0y) begin
        tx = v0x; ty = v0y; v0x = v1x; v0y = v1y; v1x = tx; v1y = ty;
      end
    end
  end

  // current part geometry from the sorted vertices
  logic [7:0] g_apx, g_ex1, g_ex2, g_top, g_bot;
  logic       g_up;
  always_comb begin
    logic [7:0] px, qx;
    if (v1y == v2y) begin
      g_up = 1'b0; g_apx = v0x; px = v1x; qx = v2x; g_top = v0y; g_bot = v1y;
    end else if (v0y == v1y) begin
      g_up = 1'b1; g_apx = v2x; px = v0x; qx = v1x; g_top = v0y; g_bot = v2y;
    end else if (!part_cur) begin
      g_up = 1'b0; g_apx = v0x; px = v1x; qx = mid_x; g_top = v0y; g_bot = v1y;
    end else begin
      g_up = 1'b1; g_apx = v2x; px = v1x; qx = mid_x; g_top = v1y; g_bot = v2y;
    end
    g_ex1 = (px > qx) ? qx : px;
    g_ex2 = (px > qx) ? px : qx;
  end

  // divider operands
  always_comb begin
    logic signed [8:0] dx;
    logic [8:0] mag;
    logic [7:0] ex;
    logic [15:0] dy;
    ex   = (cmd.div_sel == ftzr_pkg::DIV_S2) ? g_ex2 : g_ex1;
    dy   = {8'd0, g_bot - g_top};
    dx   = $signed({1'b0, ex}) - $signed({1'b0, g_apx});
    if (g_up) dx = -dx;
    mag  = dx[8] ? 9'(-dx) : 9'(dx);
    dneg = dx[8];
    dnum = {6'd0, mag, 17'd0} + {16'd0, dy};
    dden = {dy[14:0], 1'b0};
    if (cmd.div_sel == ftzr_pkg::DIV_MID) begin
      // 2*(x1*d13 + (x3-x1)*(y2-y1)) + d13 over 2*d13
      dneg = 1'b0;
      dy   = {8'd0, v2y - v0y};
      dnum = 32'($signed({1'b0, v0x}) * $signed({1'b0, dy[8:0]})
           + ($signed({1'b0, v2x}) - $signed({1'b0, v0x}))
             * $signed({1'b0, v1y - v0y}));
      dnum = {dnum[30:0], 1'b0} + {16'd0, dy};
      dden = {dy[14:0], 1'b0};
    end
  end

  // round half up of signed 10.16 to a pixel column
  function automatic logic signed [9:0] rnd(input logic signed [25:0] v);
    logic signed [25:0] t;
    t = v + 26'sd32768;
    return 10'(t >>> 16);
  endfunction

  logic signed [9:0] r_lo, r_hi;
  logic [8:0] c_lo, c_hi;
  logic       row_empty;
  always_comb begin
    r_lo = rnd(e1);
    r_hi = rnd(e2);
    c_lo = (r_lo < 0) ? 9'd0 : 9'(r_lo);
    c_hi = (32'(r_hi) > SCREEN_WIDTH - 1) ? 9'(SCREEN_WIDTH - 1) : 9'(r_hi);
    row_empty = (r_hi < 0) || (r_lo > r_hi) || (c_lo > c_hi)
              || (32'(row) >= SCREEN_HEIGHT) || (32'(c_lo) >= SCREEN_WIDTH);
  end

  logic span_bad;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] rd_addr;
  assign pix_addr = {YW'(row), XW'(cur)};
  assign cur_nx   = cmd.pix_adv ? cur + 9'd1 : cur;
  assign rd_addr  = cmd.read_issue ? {YW'(ay), XW'(ax)} : {YW'(row), XW'(cur_nx)};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      cmem[clr_cnt[AW-1:0]] <= '0;
      dmem[clr_cnt[AW-1:0]] <= 16'hFFFF;
    end else if (cmd.pix_eval && dep < rd_d) begin
      cmem[pix_addr] <= col;
      dmem[pix_addr] <= dep;
    end
    if (cmd.rd_issue || cmd.read_issue) begin
      rd_c <= cmem[rd_addr];
      rd_d <= dmem[rd_addr];
    end
  end

  logic rd_oob;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action; ax <= x_a; ay <= y_a; bx <= x_b; by <= y_b;
      cx <= x_c; cy <= y_c; dep <= tri_depth; col <= tri_color;
      part <= 1'b0; cnt <= '0;
    end
    if (cmd.read_issue)
      rd_oob <= (32'(ax) >= SCREEN_WIDTH) || (32'(ay) >= SCREEN_HEIGHT);
    if (cmd.div_start) dneg_r <= dneg;
    if (ddone) begin
      if (st.need_mid && !two_part_seen) mx <= dquo[7:0];
      else if (s_sel == 1'b0) s1 <= dneg_r ? -$signed(dquo[25:0]) : $signed(dquo[25:0]);
      else s2 <= dneg_r ? -$signed(dquo[25:0]) : $signed(dquo[25:0]);
    end
    if (cmd.part_init) begin
      e1 <= {g_apx, 16'd0}; e2 <= {g_apx, 16'd0};
      up <= g_up;
      row <= g_up ? g_bot : g_top;
      p_ay <= g_up ? g_top : g_bot;
    end
    if (cmd.row_init) begin
      hi <= c_hi; cur <= c_lo; span_bad <= row_empty;
    end
    if (cmd.pix_adv) cur <= cur + 1'b1;
    if (cmd.pix_eval && dep < rd_d) cnt <= cnt + 1'b1;
    if (cmd.row_adv) begin
      if (up) begin
        row <= row - 1'b1; e1 <= e1 - s1; e2 <= e2 - s2;
      end else begin
        row <= row + 1'b1; e1 <= e1 + s1; e2 <= e2 + s2;
      end
    end
    if (cmd.part_adv) part <= 1'b1;
    if (cmd.out_load) begin
      if (act) begin
        pixel_color <= rd_oob ? 24'd0 : rd_c;
        pixel_depth <= rd_oob ? 16'hFFFF : rd_d;
        pixels_written <= '0;
      end else begin
        pixel_color <= '0; pixel_depth <= '0; pixels_written <= cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      two_part_seen <= (cmd.div_sel != ftzr_pkg::DIV_MID);
      s_sel         <= (cmd.div_sel == ftzr_pkg::DIV_S2);
    end
  end

  assign two_part = (v1y != v2y) && (v0y != v1y);

  assign st.is_read    = act;
  assign st.flat       = (v0y == v1y) && (v1y == v2y);
  assign st.div_done   = ddone;
  assign st.clr_last   = (clr_cnt == CLW'(DEPTH - 1));
  assign st.span_empty = span_bad;
  assign st.pix_last   = (cur == hi);
  assign st.row_last   = (row == p_ay);
  assign st.part_last  = !two_part || part;
  assign st.need_mid   = two_part;
  assign st.part_skip  = 1'b0;
endmodule

@@ rtl/flat_triangle_zbuffer_raster_core.sv @@
// Flat triangle rasteriser with colour and depth stores.
// Read request: the stores are read in the setup state and the result is
// loaded in the result state. Draw request: two divisions per part, one
// more for the split vertex of a general triangle.
// One request in flight; the next is taken once the result is loaded and the
// previous result has gone. Reset: a clearing pass over every store entry
// (SCREEN_WIDTH*SCREEN_HEIGHT for powers of two) takes no requests.
module flat_triangle_zbuffer_raster_core #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  x_a,
  input  logic [7:0]  y_a,
  input  logic [7:0]  x_b,
  input  logic [7:0]  y_b,
  input  logic [7:0]  x_c,
  input  logic [7:0]  y_c,
  input  logic [15:0] tri_depth,
  input  logic [23:0] tri_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] pixel_color,
  output logic [15:0] pixel_depth,
  output logic [16:0] pixels_written
);
  ftzr_pkg::cmd_t  cmd;
  ftzr_pkg::stat_t st;

  // sequencer: clear pass, slope divisions, row and pixel walk
  ftzr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd)
  );

  // geometry, stores and result register
  ftzr_dp #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .action(action),
    .x_a(x_a), .y_a(y_a), .x_b(x_b), .y_b(y_b), .x_c(x_c), .y_c(y_c),
    .tri_depth(tri_depth), .tri_color(tri_color),
    .pixel_color(pixel_color), .pixel_depth(pixel_depth),
    .pixels_written(pixels_written)
  );
endmodule

@@ rtl/ftzr_checker.sv @@
// Port-level checks for the raster core, bound to the top level.
module ftzr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] pixels_written
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("second request taken");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pixels_written)))
    else $error("result dropped");
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid)) else $error("result too early");
endmodule

bind flat_triangle_zbuffer_raster_core ftzr_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .pixels_written(pixels_written)
);
